// File: rtl/dis_pkg.sv
package dis_pkg;

   localparam int PIX_W        = 8;
   localparam int COL_OUT_W    = 11;
   localparam int ROW_W        = 12;
   localparam int SUM_W        = 11;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int MARGIN_W     = 11;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 32;
   localparam int RSP_PAD_W    = RSP_DATA_W - PIX_W - COL_OUT_W - ROW_W;

   localparam int MIN_DIM      = 3;
   localparam int HEIGHT_LIMIT = 4096;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GRADIENT_MARGIN = 2'd2;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [MARGIN_W-1:0]     MARGIN_RESET = 11'd20;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [SUM_W-1:0] sum_type;

   // gradient sums, extreme tests and candidate means of one window
   typedef struct packed {
      sum_type sx;
      sum_type sy;
      logic    ext_h;
      logic    ext_v;
      logic    above;
      logic    below;
      pix_type mean_h;
      pix_type mean_v;
      pix_type mean_top;
      pix_type mean_bot;
      pix_type ct;
   } calc_type;

   function automatic pix_type absdiff(pix_type a, pix_type b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic pix_type mean2(pix_type a, pix_type b);
      logic [PIX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[PIX_W:1];
   endfunction

endpackage

// File: rtl/directional_impulse_smoother_core.sv
// Directional impulse smoother for one 8-bit plane in raster order.
// req_* takes one source pixel per word; rsp_* returns one filtered or
// passed-through pixel per word with its column and row, tlast on the
// final pixel of the plane. Every pixel comes out exactly once: interior
// pixel (r-1,c-1) follows the arrival of (r,c), border pixels follow their
// own arrival. The upper window row uses already filtered values.
// Throughput is one pixel per clock while rsp_tready is high. A pixel that
// releases two results (right column from row 2 on, last row from column
// 2 on) holds the output stage for its second word, since the output
// register takes one word per clock. Widths of four or less stall input
// while the filtered line buffer still has a write pending to the column
// being read. A pixel passes the line buffer read, window and gradient
// sums, and direction choice into the output register. Reset clears the
// pipeline, output and position, and restores the registers (width 640,
// height 480, margin 20). A csr write to width, height or margin restarts
// the frame at pixel (0,0). When rsp_tready is low the pipeline keeps
// taking pixels until its stages fill, then drops req_tready.
module directional_impulse_smoother_core
   import dis_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // pixel_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // pixel_out, out_col, out_row, zero pad
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);

   typedef logic [AW-1:0]    col_type;
   typedef logic [ROW_W-1:0] row_type;

   typedef struct packed {
      col_type col;
      row_type row;
      pix_type pix;
      logic    filt;
      logic    border;
      logic    last;
      logic    wr_en;
      col_type wr_addr;
   } tag_type;

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [MARGIN_W-1:0]     margin_ff, margin_in;
   logic                    cfg_hit;
   logic [31:0]             width_ext, width_eff, height_ext, height_eff;
   col_type                 last_col;
   row_type                 last_row;

   col_type col_ff, col_in;
   row_type row_ff, row_in;
   tag_type s0_tag;
   logic    hazard, accept;

   logic    v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic    ready1, ready2, ready3, adv1, adv2, s3_go;
   tag_type t1_ff, t2_ff, t3_ff;
   pix_type up_rd_ff, mid_rd_ff, up_val, mid_val;
   pix_type win_ff [9];
   calc_type calc, c3_ff;

   pix_type ul, up, ur, lf, ct, rt, dl, dn, dr;
   pix_type hi_a, lo_a, hi_b, lo_b, top1, top2, bot1, bot2;

   logic [SUM_W:0] sx_w, sy_w, marg_w;
   logic           pick_h, pick_v;
   pix_type        f_val, up_wr_val;

   logic    sent_ff, sent_in, emit_filt, pend, out_free, out_load;
   logic    rsp_valid_ff, rsp_valid_in, rsp_last_ff;
   pix_type rsp_pix_ff;
   logic [COL_OUT_W-1:0] rsp_col_ff;
   row_type rsp_row_ff;

   pix_type up_mem  [MAX_WIDTH];
   pix_type mid_mem [MAX_WIDTH];

   // configuration
   assign cfg_hit = csr_wr_en && (csr_index == REG_IMAGE_WIDTH ||
                                  csr_index == REG_IMAGE_HEIGHT ||
                                  csr_index == REG_GRADIENT_MARGIN);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      margin_in = margin_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:     width_in  = csr_wdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT:    height_in = csr_wdata[HEIGHT_REG_W-1:0];
            REG_GRADIENT_MARGIN: margin_in = csr_wdata[MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      width_ext  = 32'(width_ff);
      height_ext = 32'(height_ff);
      if (width_ext < 32'(MIN_DIM)) width_eff = 32'(MIN_DIM);
      else if (width_ext > 32'(MAX_WIDTH)) width_eff = 32'(MAX_WIDTH);
      else width_eff = width_ext;
      if (height_ext < 32'(MIN_DIM)) height_eff = 32'(MIN_DIM);
      else if (height_ext > 32'(HEIGHT_LIMIT)) height_eff = 32'(HEIGHT_LIMIT);
      else height_eff = height_ext;
      last_col = AW'(width_eff - 32'd1);
      last_row = ROW_W'(height_eff - 32'd1);
   end

   // position and input word
   always_comb begin
      s0_tag.col     = col_ff;
      s0_tag.row     = row_ff;
      s0_tag.pix     = req_tdata[PIX_W-1:0];
      s0_tag.filt    = (row_ff >= row_type'(2)) && (col_ff >= col_type'(2));
      s0_tag.border  = (row_ff == '0) || (row_ff == last_row) ||
                       (col_ff == '0) || (col_ff == last_col);
      s0_tag.last    = (row_ff == last_row) && (col_ff == last_col);
      s0_tag.wr_en   = (col_ff != '0) ? (row_ff != '0) : (row_ff >= row_type'(2));
      s0_tag.wr_addr = (col_ff == '0) ? last_col : col_ff - 1'b1;
   end

   assign hazard = (row_ff >= row_type'(2)) &&
                   ((v1_ff && t1_ff.wr_en && t1_ff.wr_addr == col_ff) ||
                    (v2_ff && t2_ff.wr_en && t2_ff.wr_addr == col_ff) ||
                    (v3_ff && t3_ff.wr_en && t3_ff.wr_addr == col_ff));

   assign req_tready = ready1 && !hazard;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == last_col) begin
            col_in = '0;
            row_in = (row_ff == last_row) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // stage handshake
   assign ready3 = !v3_ff || s3_go;
   assign adv2   = v2_ff && ready3;
   assign ready2 = !v2_ff || ready3;
   assign adv1   = v1_ff && ready2;
   assign ready1 = !v1_ff || ready2;

   assign v1_in = accept || (v1_ff && !adv1);
   assign v2_in = adv1 || (v2_ff && !adv2);
   assign v3_in = adv2 || (v3_ff && !s3_go);

   // line buffers
   always_ff @(posedge clock) begin
      if (accept) begin
         mid_rd_ff       <= mid_mem[col_ff];
         mid_mem[col_ff] <= s0_tag.pix;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         up_rd_ff <= up_mem[col_ff];
      end
      if (s3_go && t3_ff.wr_en) begin
         up_mem[t3_ff.wr_addr] <= up_wr_val;
      end
   end

   // window
   assign up_val  = (t1_ff.row >= row_type'(2)) ? up_rd_ff : '0;
   assign mid_val = (t1_ff.row != '0) ? mid_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (accept) begin
         t1_ff <= s0_tag;
      end
      if (adv1) begin
         t2_ff     <= t1_ff;
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= up_val;
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= mid_val;
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= t1_ff.pix;
      end
      if (adv2) begin
         t3_ff <= t2_ff;
         c3_ff <= calc;
      end
   end

   // gradient sums and candidates
   always_comb begin
      ul = win_ff[0]; up = win_ff[1]; ur = win_ff[2];
      lf = win_ff[3]; ct = win_ff[4]; rt = win_ff[5];
      dl = win_ff[6]; dn = win_ff[7]; dr = win_ff[8];

      hi_a = (up > dn) ? up : dn;
      lo_a = (up > dn) ? dn : up;
      hi_b = (lf > rt) ? lf : rt;
      lo_b = (lf > rt) ? rt : lf;
      top1 = (hi_a > hi_b) ? hi_a : hi_b;
      top2 = (hi_a > hi_b) ? ((lo_a > hi_b) ? lo_a : hi_b)
                           : ((lo_b > hi_a) ? lo_b : hi_a);
      bot1 = (lo_a < lo_b) ? lo_a : lo_b;
      bot2 = (lo_a < lo_b) ? ((hi_a < lo_b) ? hi_a : lo_b)
                           : ((hi_b < lo_a) ? hi_b : lo_a);

      calc.sx = SUM_W'(absdiff(ul, up)) + SUM_W'(absdiff(up, ur)) +
                SUM_W'(absdiff(lf, ct)) + SUM_W'(absdiff(ct, rt)) +
                SUM_W'(absdiff(dl, dn)) + SUM_W'(absdiff(dn, dr));
      calc.sy = SUM_W'(absdiff(ul, lf)) + SUM_W'(absdiff(lf, dl)) +
                SUM_W'(absdiff(up, ct)) + SUM_W'(absdiff(ct, dn)) +
                SUM_W'(absdiff(ur, rt)) + SUM_W'(absdiff(rt, dr));
      calc.ext_h    = (ct > lf && ct > rt) || (ct < lf && ct < rt);
      calc.ext_v    = (ct > up && ct > dn) || (ct < up && ct < dn);
      calc.above    = ct > up && ct > dn && ct > lf && ct > rt;
      calc.below    = ct < up && ct < dn && ct < lf && ct < rt;
      calc.mean_h   = mean2(lf, rt);
      calc.mean_v   = mean2(up, dn);
      calc.mean_top = mean2(top1, top2);
      calc.mean_bot = mean2(bot1, bot2);
      calc.ct       = ct;
   end

   // direction choice
   assign sx_w   = {1'b0, c3_ff.sx};
   assign sy_w   = {1'b0, c3_ff.sy};
   assign marg_w = {1'b0, margin_ff};
   assign pick_h = sy_w > sx_w + marg_w;
   assign pick_v = sx_w > sy_w + marg_w;

   always_comb begin
      priority if (pick_h) begin
         f_val = c3_ff.ext_h ? c3_ff.mean_h : c3_ff.ct;
      end else if (pick_v) begin
         f_val = c3_ff.ext_v ? c3_ff.mean_v : c3_ff.ct;
      end else if (c3_ff.above) begin
         f_val = c3_ff.mean_top;
      end else if (c3_ff.below) begin
         f_val = c3_ff.mean_bot;
      end else begin
         f_val = c3_ff.ct;
      end
   end

   assign up_wr_val = t3_ff.filt ? f_val : c3_ff.ct;

   // output: filtered word first, then the border word
   assign emit_filt = t3_ff.filt && !sent_ff;
   assign pend      = emit_filt || t3_ff.border;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign out_load  = v3_ff && pend && out_free;
   assign s3_go     = v3_ff && (!pend || (out_free && !(emit_filt && t3_ff.border)));
   assign sent_in   = s3_go ? 1'b0 : (out_load ? 1'b1 : sent_ff);
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (emit_filt) begin
            rsp_pix_ff  <= f_val;
            rsp_col_ff  <= COL_OUT_W'(t3_ff.col - 1'b1);
            rsp_row_ff  <= t3_ff.row - 1'b1;
            rsp_last_ff <= 1'b0;
         end else begin
            rsp_pix_ff  <= t3_ff.pix;
            rsp_col_ff  <= COL_OUT_W'(t3_ff.col);
            rsp_row_ff  <= t3_ff.row;
            rsp_last_ff <= t3_ff.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         margin_ff    <= MARGIN_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         sent_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         margin_ff    <= margin_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_row_ff, rsp_col_ff, rsp_pix_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/dis_checker.sv
module dis_checker
   import dis_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // the final pixel of a plane sits at row two or beyond
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[30:20] != 11'd0)
      else $error("tlast on a row below two");

   // the word after a plane's last belongs to row zero
   a_new_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid || rsp_tdata[30:19] == 12'd0)
      else $error("new plane does not start on row zero");

endmodule

bind directional_impulse_smoother_core dis_checker u_dis_checker (.*);

// File: dv/directional_impulse_smoother_core_tb.sv
`timescale 1ns / 100ps

module directional_impulse_smoother_core_tb;
   import dis_pkg::*;

   localparam int LINE_MAX    = 2048;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int SETTLE_CYC  = 10;
   localparam int SHOW_MAX    = 10;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef enum {PAT_NOISE, PAT_IMPULSE, PAT_VSTRIPE, PAT_HSTRIPE, PAT_RAMP} pattern_type;

   typedef struct packed {
      logic                 last;
      logic [ROW_W-1:0]     row;
      logic [COL_OUT_W-1:0] col;
      pix_type              pix;
   } px_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // pixel_in
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // pixel_out, out_col, out_row, zero pad
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   directional_impulse_smoother_core #(
      .MAX_WIDTH(LINE_MAX)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [WIDTH_REG_W-1:0]  cfg_width  = WIDTH_RESET;
   logic [HEIGHT_REG_W-1:0] cfg_height = HEIGHT_RESET;
   logic [MARGIN_W-1:0]     cfg_margin = MARGIN_RESET;
   pix_type                 filt_line [0:LINE_MAX-1];
   pix_type                 src_line  [0:LINE_MAX-1];
   pix_type                 win_px    [0:8];
   int                      pos_col = 0;
   int                      pos_row = 0;
   px_word_type             smoothed_px_q [$];

   int       mismatch_count = 0;
   int       cycle_count    = 0;
   bit       req_gaps_on    = 1'b1;
   bit       rsp_gaps_on    = 1'b1;
   int       rsp_hold_len   = 0;
   pix_type  pat_lo = 8'd0;
   pix_type  pat_hi = 8'd0;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int absd(int a, int b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic pix_type smooth_centre();
      int ul, up, ur, lf, ct, rt, dl, dn, dr, sx, sy, t;
      int nb [4];
      ul = win_px[0]; up = win_px[1]; ur = win_px[2];
      lf = win_px[3]; ct = win_px[4]; rt = win_px[5];
      dl = win_px[6]; dn = win_px[7]; dr = win_px[8];
      sx = absd(ul, up) + absd(up, ur) + absd(lf, ct) + absd(ct, rt)
         + absd(dl, dn) + absd(dn, dr);
      sy = absd(ul, lf) + absd(lf, dl) + absd(up, ct) + absd(ct, dn)
         + absd(ur, rt) + absd(rt, dr);
      if (sy - sx > int'(cfg_margin)) begin
         if ((ct > lf && ct > rt) || (ct < lf && ct < rt))
            return pix_type'((lf + rt) >> 1);
      end else if (sx - sy > int'(cfg_margin)) begin
         if ((ct > up && ct > dn) || (ct < up && ct < dn))
            return pix_type'((up + dn) >> 1);
      end else begin
         nb[0] = up; nb[1] = dn; nb[2] = lf; nb[3] = rt;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3 - i; j++) begin
               if (nb[j] > nb[j+1]) begin
                  t = nb[j]; nb[j] = nb[j+1]; nb[j+1] = t;
               end
            end
         end
         if (ct > nb[3]) return pix_type'((nb[3] + nb[2]) >> 1);
         if (ct < nb[0]) return pix_type'((nb[0] + nb[1]) >> 1);
      end
      return pix_type'(ct);
   endfunction

   task automatic predict_smoothed(input pix_type p);
      int w, h, c, r;
      pix_type upv, midv, f;
      px_word_type word;
      w = cfg_width;
      h = cfg_height;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > LINE_MAX) w = LINE_MAX;
      if (h < MIN_DIM) h = MIN_DIM;
      if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
      c = (pos_col >= w) ? w - 1 : pos_col;
      r = (pos_row >= h) ? h - 1 : pos_row;
      upv = '0;
      midv = '0;
      if (r >= 2) upv = filt_line[c];
      if (r >= 1) begin
         midv = src_line[c];
         filt_line[c] = midv;
      end
      src_line[c] = p;
      for (int i = 0; i < 3; i++) begin
         win_px[i*3]   = win_px[i*3+1];
         win_px[i*3+1] = win_px[i*3+2];
      end
      win_px[2] = upv;
      win_px[5] = midv;
      win_px[8] = p;
      if (r >= 2 && c >= 2) begin
         f = smooth_centre();
         filt_line[c-1] = f;
         word.pix  = f;
         word.col  = COL_OUT_W'(c - 1);
         word.row  = ROW_W'(r - 1);
         word.last = 1'b0;
         smoothed_px_q.push_back(word);
      end
      if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
         word.pix  = p;
         word.col  = COL_OUT_W'(c);
         word.row  = ROW_W'(r);
         word.last = (r == h - 1 && c == w - 1);
         smoothed_px_q.push_back(word);
      end
      if (c + 1 >= w) begin
         pos_col = 0;
         pos_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         pos_col = c + 1;
         pos_row = r;
      end
   endtask

   // wait until every expected word is out, then let the pipeline drain
   task automatic settle();
      while (smoothed_px_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_IMAGE_WIDTH:     cfg_width  = val[WIDTH_REG_W-1:0];
         REG_IMAGE_HEIGHT:    cfg_height = val[HEIGHT_REG_W-1:0];
         REG_GRADIENT_MARGIN: cfg_margin = val[MARGIN_W-1:0];
         default: ;
      endcase
      if (idx != REG_UNUSED) begin
         pos_col = 0;
         pos_row = 0;
      end
   endtask

   task automatic set_plane(input int w, input int h, input int margin);
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(h));
      write_reg(REG_GRADIENT_MARGIN, CSR_DATA_W'(margin));
   endtask

   task automatic send_pixel(input pix_type p);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      do @(posedge clock); while (!req_tready);
      predict_smoothed(p);
   endtask

   function automatic pix_type pattern_pixel(pattern_type pat, int r, int c);
      int roll;
      roll = $urandom_range(0, 99);
      if (pat != PAT_NOISE && roll < 18) begin
         if (roll < 6) return 8'hFF;
         if (roll < 12) return 8'h00;
         return pix_type'($urandom_range(0, 255));
      end
      case (pat)
         PAT_IMPULSE: return pix_type'(pat_lo + $urandom_range(0, 2));
         PAT_VSTRIPE: return (c % 2) ? pat_hi : pat_lo;
         PAT_HSTRIPE: return (r % 2) ? pat_hi : pat_lo;
         PAT_RAMP:    return pix_type'(pat_lo + 4 * c + 2 * r + $urandom_range(0, 3));
         default:     return pix_type'($urandom_range(0, 255));
      endcase
   endfunction

   // send pixels first .. first+count-1 of a plane of width w
   task automatic send_plane(input int w, input int first, input int count,
                             input pattern_type pat);
      for (int k = first; k < first + count; k++)
         send_pixel(pattern_pixel(pat, k / w, k % w));
      req_tvalid <= 1'b0;
   endtask

   task automatic send_list(input pix_type px [$]);
      foreach (px[i]) send_pixel(px[i]);
      req_tvalid <= 1'b0;
   endtask

   task automatic test_reset_values();
      pat_lo = 8'd90;
      send_plane(640, 0, 16, PAT_IMPULSE);
      settle();
      // keep the margin from reset
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(6));
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(4));
      send_plane(6, 0, 24, PAT_IMPULSE);
      settle();
   endtask

   task automatic test_directed();
      pix_type px [$];
      set_plane(3, 3, 20);
      px = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
      send_list(px);
      set_plane(5, 3, 0);
      px = '{8'd40, 8'd40, 8'd40, 8'd40, 8'd40,
             8'd200, 8'd10, 8'd200, 8'd60, 8'd250,
             8'd40, 8'd40, 8'd40, 8'd40, 8'd40};
      send_list(px);
      settle();
   endtask

   task automatic test_unused_index();
      set_plane(6, 4, 10);
      send_plane(6, 0, 10, PAT_NOISE);
      write_reg(REG_UNUSED, '1);
      send_plane(6, 10, 14, PAT_NOISE);
      settle();
   endtask

   task automatic test_random_planes();
      int done_px, w, h, m, n, roll;
      pattern_type pat;
      done_px = 0;
      while (done_px < 200) begin
         roll = $urandom_range(0, 9);
         w = (roll < 8) ? $urandom_range(3, 10) : $urandom_range(11, 24);
         h = $urandom_range(3, 7);
         roll = $urandom_range(0, 9);
         if (roll == 0) m = 0;
         else if (roll == 1) m = 1530;
         else if (roll == 2) m = 2047;
         else if (roll < 7) m = $urandom_range(0, 60);
         else m = $urandom_range(0, 1530);
         set_plane(w, h, m);
         pat = pattern_type'($urandom_range(0, 4));
         pat_lo = pix_type'($urandom_range(0, 255));
         pat_hi = pix_type'($urandom_range(0, 255));
         n = ($urandom_range(0, 6) == 0) ? $urandom_range(1, w * h - 1) : w * h;
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         send_plane(w, 0, n, pat);
         done_px += n;
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      settle();
   endtask

   task automatic test_backpressure();
      set_plane(8, 6, 20);
      req_gaps_on = 1'b0;
      rsp_hold_len = 300;
      // start sending once the hold-off is running
      wait (rsp_hold_len == 0);
      send_plane(8, 0, 24, PAT_HSTRIPE);
      // pause mid-plane until every word is out
      while (smoothed_px_q.size() != 0) @(posedge clock);
      req_gaps_on = 1'b1;
      send_plane(8, 24, 24, PAT_VSTRIPE);
      settle();
   endtask

   task automatic test_wide_plane();
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(12'hFFF));
      write_reg(REG_IMAGE_HEIGHT, '0);
      write_reg(REG_GRADIENT_MARGIN, CSR_DATA_W'(11'h7FF));
      send_plane(LINE_MAX, 0, 24, PAT_NOISE);
      settle();
   endtask

   task automatic test_tall_plane();
      write_reg(REG_IMAGE_WIDTH, '0);
      write_reg(REG_IMAGE_HEIGHT, '1);
      write_reg(REG_GRADIENT_MARGIN, '0);
      pat_lo = 8'd30;
      pat_hi = 8'd220;
      send_plane(MIN_DIM, 0, MIN_DIM * 10, PAT_HSTRIPE);
      settle();
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin : rsp_ready_drive
      int n;
      @(posedge clock);
      forever begin
         if (rsp_hold_len > 0) begin
            n = rsp_hold_len;
            rsp_hold_len = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = rsp_gaps_on ? pick_gap() : 0;
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_words
      px_word_type want;
      px_word_type got;
      logic        pad_bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pix  = rsp_tdata[PIX_W-1:0];
         got.col  = rsp_tdata[PIX_W +: COL_OUT_W];
         got.row  = rsp_tdata[PIX_W+COL_OUT_W +: ROW_W];
         got.last = rsp_tlast;
         pad_bad  = (rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W] != '0);
         if (smoothed_px_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_MAX)
               $display("%0t: unexpected word pix=%0d col=%0d row=%0d last=%0b",
                        $realtime, got.pix, got.col, got.row, got.last);
         end else begin
            want = smoothed_px_q.pop_front();
            if (got.pix != want.pix || got.col != want.col || got.row != want.row
                || got.last != want.last || pad_bad) begin
               mismatch_count++;
               if (mismatch_count <= SHOW_MAX) begin
                  $write("%0t: mismatch exp pix=%0d col=%0d row=%0d last=%0b",
                         $realtime, want.pix, want.col, want.row, want.last);
                  $display(" got pix=%0d col=%0d row=%0d last=%0b pad=%0h",
                           got.pix, got.col, got.row, got.last,
                           rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < LINE_MAX; i++) begin
         filt_line[i] = '0;
         src_line[i]  = '0;
      end
      for (int i = 0; i < 9; i++) win_px[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed();
      test_unused_index();
      test_random_planes();
      test_backpressure();
      test_wide_plane();
      test_tall_plane();
      settle();
      if (mismatch_count == 0 && smoothed_px_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
